// ===== rtl/core/iorob_pkg.sv =====
package iorob_pkg;

  // Default sizes of the reorder window and of the channel fields.
  localparam int DEF_WINDOW_DEPTH = 16;
  localparam int DEF_PAYLOAD_BITS = 32;
  localparam int DEF_TAG_BITS     = 16;

  // Commands from the sequencer to the slot store.
  typedef struct packed {
    logic wr_en;   // park a payload and mark its slot busy
    logic rd_en;   // fetch a parked payload, data in the following cycle
    logic clr_en;  // free the slot whose payload is being released
  } mem_ctl_t;

endpackage

// ===== rtl/core/iorob_if.sv =====
interface iorob_in_if #(
  parameter int TAG_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic [TAG_BITS-1:0]     seq_tag;
  logic [PAYLOAD_BITS-1:0] payload;

  modport source (output valid, output seq_tag, output payload, input ready);
  modport sink (input valid, input seq_tag, input payload, output ready);
endinterface

interface iorob_out_if #(
  parameter int TAG_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [TAG_BITS-1:0]     out_tag;
  logic                    dropped;
  logic                    last_of_run;

  modport source (output valid, output out_payload, output out_tag, output dropped,
                  output last_of_run, input ready);
  modport sink (input valid, input out_payload, input out_tag, input dropped,
                input last_of_run, output ready);
endinterface

// ===== rtl/core/iorob_slot_store.sv =====
module iorob_slot_store #(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32,
  parameter int SW           = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  iorob_pkg::mem_ctl_t     ctl,
  input  logic [SW-1:0]           wr_addr,
  input  logic [PAYLOAD_BITS-1:0] wr_data,
  input  logic [SW-1:0]           rd_addr,
  input  logic [SW-1:0]           clr_addr,
  output logic [PAYLOAD_BITS-1:0] rd_data,
  output logic [DEPTH-1:0]        slot_valid
);
  import iorob_pkg::*;

  logic [PAYLOAD_BITS-1:0] mem_r [DEPTH];
  logic [PAYLOAD_BITS-1:0] rd_data_r;
  logic [DEPTH-1:0]        valid_r;

  // Payload memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // Busy marks live in flops so that reset empties the window at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (ctl.clr_en) begin
        valid_r[clr_addr] <= 1'b0;
      end
      if (ctl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data    = rd_data_r;
  assign slot_valid = valid_r;

endmodule

// ===== rtl/core/in_order_release_reorder_buffer_top.sv =====
// In-order release reorder buffer.
//
// Items arrive on in_chan carrying a sequence tag and a payload handle, in any
// order. Results leave on out_chan strictly in tag order. An item whose tag is
// the expected one is released at once, followed by every consecutively tagged
// payload already parked in the window. An item ahead of the expected tag but
// inside the window is parked and gives no result. An item outside the window,
// or one whose slot is already busy, gives one result with dropped set.
// last_of_run marks the final result caused by each accepted item.
//
// A result is in the output register in the cycle after its item is accepted.
// An item that parks, drops or releases with nothing behind it leaves the
// sequencer idle. A release that drains parked payloads sends them out one at
// a time, as the payload memory has a single read port; in_chan.ready
// stays low during the drain.
// Reset (synchronous, rst_n low) sets the expected tag to zero and marks every
// slot empty in the same cycle; there is no clearing pass.
// When the receiver stalls, the output register holds its result, the drain
// pauses, and no new item is accepted until the register can be refilled.
module in_order_release_reorder_buffer_top #(
  parameter int WINDOW_DEPTH = iorob_pkg::DEF_WINDOW_DEPTH,
  parameter int PAYLOAD_BITS = iorob_pkg::DEF_PAYLOAD_BITS,
  parameter int TAG_BITS     = iorob_pkg::DEF_TAG_BITS
) (
  input logic  clk,
  input logic  rst_n,
  iorob_in_if.sink    in_chan,
  iorob_out_if.source out_chan
);
  import iorob_pkg::*;

  localparam int SW = $clog2(WINDOW_DEPTH);
  // Width wide enough to compare a tag distance against the window depth.
  localparam int CW = ((TAG_BITS > SW) ? TAG_BITS : SW) + 2;

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  state_t                  state_r;
  logic                    out_valid_r;
  logic [PAYLOAD_BITS-1:0] out_payload_r;
  logic [TAG_BITS-1:0]     out_tag_r;
  logic                    out_dropped_r;
  logic                    out_last_r;
  logic [TAG_BITS-1:0]     exp_tag_r;
  // Follows exp_tag_r modulo WINDOW_DEPTH and returns to zero when the tag wraps, kept without a divider.
  logic [SW-1:0]           exp_slot_r;

  logic                    out_free;
  logic                    in_ready;
  logic                    in_fire;
  logic [TAG_BITS-1:0]     tag_gap;
  logic                    in_window;
  logic                    is_rel;
  logic [SW:0]             slot_sum;
  logic [SW:0]             slot_sum_w;
  logic                    tag_wrapped;
  logic [SW-1:0]           park_slot;
  logic                    busy;
  logic [TAG_BITS-1:0]     exp_inc_tag;
  logic [SW-1:0]           exp_inc_slot;
  logic                    rel_more;
  logic                    drn_more;
  logic                    take_drop;
  logic                    take_park;
  logic                    take_rel;
  logic                    drain_step;

  mem_ctl_t                mem_ctl;
  logic [PAYLOAD_BITS-1:0] rd_data;
  logic [WINDOW_DEPTH-1:0] slot_valid;

  // The output register is free when empty or being emptied this cycle.
  assign out_free = !out_valid_r || out_chan.ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_chan.valid && in_ready;

  // Distance of the incoming tag ahead of the expected one, modulo the tag space.
  assign tag_gap   = in_chan.seq_tag - exp_tag_r;
  assign in_window = CW'(tag_gap) < CW'(WINDOW_DEPTH);
  assign is_rel    = (tag_gap == '0);

  // Slot of the incoming tag: the expected slot plus the distance, wrapped once.
  // When the tag itself wrapped past zero it is smaller than the depth and is
  // its own slot.
  assign slot_sum    = {1'b0, exp_slot_r} + (SW + 1)'(SW'(tag_gap));
  assign slot_sum_w  = (slot_sum >= (SW + 1)'(WINDOW_DEPTH)) ?
                       slot_sum - (SW + 1)'(WINDOW_DEPTH) : slot_sum;
  assign tag_wrapped = in_chan.seq_tag < exp_tag_r;
  assign park_slot   = tag_wrapped ? SW'(in_chan.seq_tag) : SW'(slot_sum_w);
  assign busy        = slot_valid[park_slot];

  // Expected tag and slot after one release.
  assign exp_inc_tag  = exp_tag_r + 1'b1;
  assign exp_inc_slot = (exp_inc_tag == '0) ? '0 :
                        (exp_slot_r == SW'(WINDOW_DEPTH - 1)) ? '0 : exp_slot_r + 1'b1;

  // During a drain the current slot is freed in the same step, so it never
  // counts as the next parked payload.
  assign rel_more = slot_valid[exp_inc_slot];
  assign drn_more = slot_valid[exp_inc_slot] && (exp_inc_slot != exp_slot_r);

  assign take_drop  = in_fire && (!in_window || (!is_rel && busy));
  assign take_park  = in_fire && in_window && !is_rel && !busy;
  assign take_rel   = in_fire && in_window && is_rel;
  assign drain_step = (state_r == S_DRAIN) && out_free;

  // The next payload is fetched as soon as the run is known to continue, so its
  // data is ready in the register of the store on the following step. Parking
  // and draining never share a cycle, and a read issued right after a park
  // already sees the written entry.
  always_comb begin
    mem_ctl.wr_en  = take_park;
    mem_ctl.rd_en  = (take_rel && rel_more) || (drain_step && drn_more);
    mem_ctl.clr_en = drain_step;
  end

  iorob_slot_store #(
    .DEPTH        (WINDOW_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .SW           (SW)
  ) u_slot_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mem_ctl),
    .wr_addr    (park_slot),
    .wr_data    (in_chan.payload),
    .rd_addr    (exp_inc_slot),
    .clr_addr   (exp_slot_r),
    .rd_data    (rd_data),
    .slot_valid (slot_valid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      exp_tag_r   <= '0;
      exp_slot_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (take_drop) begin
            out_valid_r   <= 1'b1;
            out_payload_r <= in_chan.payload;
            out_tag_r     <= in_chan.seq_tag;
            out_dropped_r <= 1'b1;
            out_last_r    <= 1'b1;
          end else if (take_rel) begin
            out_valid_r   <= 1'b1;
            out_payload_r <= in_chan.payload;
            out_tag_r     <= in_chan.seq_tag;
            out_dropped_r <= 1'b0;
            out_last_r    <= !rel_more;
            exp_tag_r     <= exp_inc_tag;
            exp_slot_r    <= exp_inc_slot;
            if (rel_more) begin
              state_r <= S_DRAIN;
            end
          end else if (out_chan.ready) begin
            // Nothing new to hold, so a result taken this cycle leaves it empty.
            out_valid_r <= 1'b0;
          end
        end
        S_DRAIN: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_payload_r <= rd_data;
            out_tag_r     <= exp_tag_r;
            out_dropped_r <= 1'b0;
            out_last_r    <= !drn_more;
            exp_tag_r     <= exp_inc_tag;
            exp_slot_r    <= exp_inc_slot;
            if (!drn_more) begin
              state_r <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_payload = out_payload_r;
  assign out_chan.out_tag     = out_tag_r;
  assign out_chan.dropped     = out_dropped_r;
  assign out_chan.last_of_run = out_last_r;

  // A drain only ever releases a slot that holds a parked payload.
  a_drain_slot_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> slot_valid[exp_slot_r])
    else $error("drain reached an empty slot");

  // The slot counter stays inside the window.
  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    exp_slot_r <= SW'(WINDOW_DEPTH - 1))
    else $error("expected slot out of range");

  // A rejected item always closes its own run.
  a_drop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dropped_r) |-> out_last_r)
    else $error("dropped result not marked last");

  // A released payload is always the one just before the expected tag.
  a_release_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_dropped_r) |-> (out_tag_r == TAG_BITS'(exp_tag_r - 1'b1)))
    else $error("released tag out of sequence");

endmodule
